FILE: hdl/gamma_contrast_brightness_pixel_macros.svh
// assertion macros used by the pixel adjust top level
`ifndef GAMMA_CONTRAST_BRIGHTNESS_PIXEL_MACROS_SVH
`define GAMMA_CONTRAST_BRIGHTNESS_PIXEL_MACROS_SVH

// same-cycle implication, checked outside reset
`define GCB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define GCB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/gcb_pkg.sv
// package: constants, tables and types of the gamma/contrast/brightness pipeline
`default_nettype none

package gcb_pkg;

    localparam int PIX_BITS  = 8;
    localparam int FRAC_BITS = 16;
    localparam int PIX_LEVELS = 1 << PIX_BITS;
    localparam int MAG_W     = 19;
    localparam int EXP_W     = FRAC_BITS + 1;
    localparam int CHAN_LAT  = 23;
    localparam int FIFO_DEPTH = 32;

    localparam logic [EXP_W-1:0] ONE_Q = EXP_W'(1) << FRAC_BITS;

    // reciprocal of 100 for the exponent scaling, exact for 27-bit operands
    localparam logic [27:0] RECIP_D = 28'd171798692;
    // reciprocal of 100 for the final quotient, exact below 25600
    localparam logic [15:0] RECIP_Q = 16'd41944;
    localparam logic [35:0] NEG_TERM = 36'd1671168000;
    localparam logic [35:0] HALF_DEN = 36'd3276800;
    localparam logic [19:0] SAT_LIM  = 20'd25600;

    typedef enum logic [1:0] {
        REG_CONTRAST   = 2'd0,
        REG_BRIGHTNESS = 2'd1,
        REG_GAMMA      = 2'd2
    } cfg_reg_t;

    typedef logic [MAG_W-1:0] mag_tab_t [PIX_LEVELS];
    typedef logic [EXP_W-1:0] exp_tab_t [FRAC_BITS];

    // fixed point log2 of an integer by repeated squaring
    function automatic logic [63:0] log2_q(input logic [63:0] p);
        int n;
        logic [63:0] m;
        logic [63:0] frac;
        n = 0;
        frac = '0;
        for (int i = 0; i < 63; i++)
        begin
            if (p[i])
            begin
                n = i;
            end
        end
        if (n <= FRAC_BITS)
        begin
            m = p << (FRAC_BITS - n);
        end
        else
        begin
            m = p >> (n - FRAC_BITS);
        end
        for (int i = 0; i < FRAC_BITS; i++)
        begin
            m = (m * m) >> FRAC_BITS;
            frac = frac << 1;
            if (m >= (64'd2 << FRAC_BITS))
            begin
                frac = frac | 64'd1;
                m = m >> 1;
            end
        end
        return (64'(n) << FRAC_BITS) | frac;
    endfunction

    // floor integer square root
    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        for (int i = 31; i >= 0; i--)
        begin
            b = 64'd1 << (2 * i);
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    // magnitude of log2(p / full scale) for every sample value
    function automatic mag_tab_t build_mag_tab();
        mag_tab_t t;
        logic [63:0] lm;
        logic [63:0] lp;
        lm = log2_q(64'(PIX_LEVELS - 1));
        t[0] = '0;
        for (int p = 1; p < PIX_LEVELS; p++)
        begin
            lp = log2_q(64'(p));
            t[p] = (lp > lm) ? '0 : MAG_W'(lm - lp);
        end
        return t;
    endfunction

    // constants 2^(2^-k), k from 1
    function automatic exp_tab_t build_exp_tab();
        exp_tab_t t;
        logic [63:0] c;
        c = isqrt64((64'd2 << FRAC_BITS) << FRAC_BITS);
        for (int k = 0; k < FRAC_BITS; k++)
        begin
            t[k] = EXP_W'(c);
            c = isqrt64(c << FRAC_BITS);
        end
        return t;
    endfunction

    localparam mag_tab_t MAG_TAB = build_mag_tab();
    localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

`default_nettype wire

FILE: hdl/gcb_chan.sv
// one colour channel: power, gain, offset, rounding and saturation pipeline
`default_nettype none

module gcb_chan
    import gcb_pkg::*;
(
    input  wire logic                clk,
    input  wire logic [PIX_BITS-1:0] pix,
    input  wire logic [7:0]          contrast,
    input  wire logic [7:0]          brightness,
    input  wire logic [7:0]          gamma,
    output logic      [PIX_BITS-1:0] res
);

    logic [26:0]           x_reg;
    logic                  za_reg;
    logic [20:0]           d_reg;
    logic                  zb_reg;
    logic [EXP_W-1:0]      r_reg [FRAC_BITS+1];
    logic [FRAC_BITS-1:0]  f_reg [FRAC_BITS+1];
    logic [4:0]            s_reg [FRAC_BITS+1];
    logic                  z_reg [FRAC_BITS+1];
    logic [17:0]           y_reg;
    logic [25:0]           m_reg;
    logic [19:0]           t_reg;
    logic                  pos_reg;
    logic [PIX_BITS-1:0]   q_reg;

    logic [54:0]           d_prod;
    logic [4:0]            ip;
    logic [FRAC_BITS-1:0]  fd;
    logic [17:0]           sh;
    logic [17:0]           y_next;
    logic [33:0]           m2;
    logic [35:0]           pos_sum;
    logic [19:0]           t_next;
    logic [30:0]           q_prod;
    logic [PIX_BITS-1:0]   q_next;

    // log magnitude times gamma, rounding half added
    always_ff @(posedge clk)
    begin
        x_reg  <= 27'(MAG_TAB[pix]) * 27'(gamma) + 27'd50;
        za_reg <= (pix == '0);
    end

    // divide by 100 through the reciprocal
    assign d_prod = 55'(x_reg) * 55'(RECIP_D);

    always_ff @(posedge clk)
    begin
        d_reg  <= d_prod[54:34];
        zb_reg <= za_reg;
    end

    // split exponent into shift and fraction
    assign ip = d_reg[20:16];
    assign fd = d_reg[FRAC_BITS-1:0];

    always_ff @(posedge clk)
    begin
        r_reg[0] <= ONE_Q;
        f_reg[0] <= FRAC_BITS'(0) - fd;
        s_reg[0] <= (fd == '0) ? ip : ip + 5'd1;
        z_reg[0] <= zb_reg;
    end

    // exp2 of the fraction, one bit per stage
    for (genvar k = 0; k < FRAC_BITS; k++)
    begin : g_exp
        logic [2*EXP_W-1:0] prod;
        assign prod = (2*EXP_W)'(r_reg[k]) * (2*EXP_W)'(EXP_TAB[k])
                    + ((2*EXP_W)'(1) << (FRAC_BITS - 1));
        always_ff @(posedge clk)
        begin
            r_reg[k+1] <= f_reg[k][FRAC_BITS-1-k] ? prod[FRAC_BITS +: EXP_W] : r_reg[k];
            f_reg[k+1] <= f_reg[k];
            s_reg[k+1] <= s_reg[k];
            z_reg[k+1] <= z_reg[k];
        end
    end

    // rounding right shift, zero sample handled apart
    assign sh = {r_reg[FRAC_BITS], 1'b0} >> s_reg[FRAC_BITS];

    always_comb
    begin
        if (z_reg[FRAC_BITS])
        begin
            y_next = (gamma == '0) ? 18'(ONE_Q) : '0;
        end
        else
        begin
            y_next = 18'((19'(sh) + 19'd1) >> 1);
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg <= y_next;
    end

    // contrast gain
    always_ff @(posedge clk)
    begin
        m_reg <= 26'(contrast) * 26'(y_reg);
    end

    // scale to full range, add offset, pre-shift the divide
    assign m2      = {m_reg, 8'b0} - 34'(m_reg);
    assign pos_sum = 36'(m2) + {4'b0, 16'(brightness * 16'd255), 16'b0};
    assign t_next  = 20'((pos_sum - NEG_TERM + HALF_DEN) >> FRAC_BITS);

    always_ff @(posedge clk)
    begin
        pos_reg <= (pos_sum > NEG_TERM);
        t_reg   <= t_next;
    end

    // divide by 100 and saturate
    assign q_prod = 31'(t_reg[14:0]) * 31'(RECIP_Q);

    always_comb
    begin
        if (!pos_reg)
        begin
            q_next = '0;
        end
        else if (t_reg >= SAT_LIM)
        begin
            q_next = '1;
        end
        else
        begin
            q_next = q_prod[29:22];
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign res = q_reg;

endmodule

`default_nettype wire

FILE: hdl/gamma_contrast_brightness_pixel.sv
// top level: gamma, contrast and brightness adjustment of an rgb pixel stream
// an accepted pixel passes the channel pipelines and is then written to the output queue before tvalid rises
// throughput: one pixel per cycle through the 23-stage channel pipelines, while credit stays below the queue depth
// a 32-entry output queue with credit count lets the pipeline run while a result waits
// reset: rst_n asynchronous, clears control and sets all three registers to 100
`default_nettype none

`include "gamma_contrast_brightness_pixel_macros.svh"

module gamma_contrast_brightness_pixel
    import gcb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // red_in, green_in, blue_in
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata   // red_out, green_out, blue_out
);

    logic [7:0]          contrast_reg;
    logic [7:0]          brightness_reg;
    logic [7:0]          gamma_reg;
    logic [CHAN_LAT-1:0] vld_reg;
    logic [5:0]          credit_reg;
    logic [5:0]          credit_next;
    logic [5:0]          fcnt_reg;
    logic [5:0]          fcnt_next;
    logic [4:0]          wr_ptr_reg;
    logic [4:0]          rd_ptr_reg;
    logic [23:0]         fifo_mem [FIFO_DEPTH];
    logic [23:0]         res;
    logic                in_xfer;
    logic                out_xfer;
    logic                push;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            contrast_reg   <= 8'd100;
            brightness_reg <= 8'd100;
            gamma_reg      <= 8'd100;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CONTRAST:   contrast_reg   <= cfg_data;
                REG_BRIGHTNESS: brightness_reg <= cfg_data;
                REG_GAMMA:      gamma_reg      <= cfg_data;
                default:        ;
            endcase
        end
    end

    // three channel pipelines
    for (genvar c = 0; c < 3; c++)
    begin : g_chan
        gcb_chan u_chan (
            .clk        (clk),
            .pix        (s_axis_tdata[c*PIX_BITS +: PIX_BITS]),
            .contrast   (contrast_reg),
            .brightness (brightness_reg),
            .gamma      (gamma_reg),
            .res        (res[c*PIX_BITS +: PIX_BITS])
        );
    end

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;
    assign push     = vld_reg[CHAN_LAT-1];

    // valid bits alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[CHAN_LAT-2:0], in_xfer};
        end
    end

    // credit: pixels in flight plus queued
    always_comb
    begin
        credit_next = credit_reg;
        if (in_xfer && !out_xfer)
        begin
            credit_next = credit_reg + 6'd1;
        end
        else if (!in_xfer && out_xfer)
        begin
            credit_next = credit_reg - 6'd1;
        end
    end

    always_comb
    begin
        fcnt_next = fcnt_reg;
        if (push && !out_xfer)
        begin
            fcnt_next = fcnt_reg + 6'd1;
        end
        else if (!push && out_xfer)
        begin
            fcnt_next = fcnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
            fcnt_reg   <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            credit_reg <= credit_next;
            fcnt_reg   <= fcnt_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 5'd1;
            end
            if (out_xfer)
            begin
                rd_ptr_reg <= rd_ptr_reg + 5'd1;
            end
        end
    end

    // output queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= res;
        end
    end

    assign s_axis_tready = (credit_reg < 6'(FIFO_DEPTH));
    assign m_axis_tvalid = (fcnt_reg != '0);
    assign m_axis_tdata  = fifo_mem[rd_ptr_reg];

    // checks
    `GCB_ASSERT_NOW(a_credit_max, 1'b1, credit_reg <= 6'(FIFO_DEPTH), "credit over queue depth")
    `GCB_ASSERT_NOW(a_fcnt_le_credit, 1'b1, fcnt_reg <= credit_reg, "queue above credit")
    `GCB_ASSERT_NEXT(a_push_fills, push, fcnt_reg != '0, "pushed result not queued")
    `GCB_ASSERT_NEXT(a_accept_counts, in_xfer && !out_xfer, credit_reg != '0, "credit lost")

endmodule

`default_nettype wire

FILE: verif/tb.sv
// testbench for the gamma, contrast and brightness pixel adjust block
`default_nettype none

module tb
    import gcb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 40;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // red_in, green_in, blue_in
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // red_out, green_out, blue_out

    // current register values as the block should hold them
    logic [7:0] gain_q;
    logic [7:0] offset_q;
    logic [7:0] gamma_q;

    logic [23:0] pixel_queue[$];
    int          n_errors;
    int          n_pixels;
    int          n_results;
    longint      cycle_count;
    logic        stall_enable;

    gamma_contrast_brightness_pixel dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // fixed point log2 by repeated squaring
    function automatic logic [63:0] pix_log2(input logic [63:0] p);
        int          top;
        logic [63:0] mant;
        logic [63:0] fbits;
        top = 0;
        fbits = '0;
        for (int i = 0; i < 63; i++)
        begin
            if (p[i])
            begin
                top = i;
            end
        end
        mant = (top <= FRAC_BITS) ? (p << (FRAC_BITS - top)) : (p >> (top - FRAC_BITS));
        for (int i = 0; i < FRAC_BITS; i++)
        begin
            mant = (mant * mant) >> FRAC_BITS;
            fbits = fbits << 1;
            if (mant >= (64'd2 << FRAC_BITS))
            begin
                fbits[0] = 1'b1;
                mant = mant >> 1;
            end
        end
        return (64'(top) << FRAC_BITS) | fbits;
    endfunction

    // floor square root
    function automatic logic [63:0] floor_sqrt(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        for (int i = 31; i >= 0; i--)
        begin
            b = 64'd1 << (2 * i);
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    // 2^f for a fraction f in [0,1)
    function automatic logic [63:0] pow2_frac(input logic [63:0] f);
        logic [63:0] acc;
        logic [63:0] root;
        acc = 64'd1 << FRAC_BITS;
        root = floor_sqrt((64'd2 << FRAC_BITS) << FRAC_BITS);
        for (int k = 1; k <= FRAC_BITS; k++)
        begin
            if (f[FRAC_BITS - k])
            begin
                acc = (acc * root + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            end
            root = floor_sqrt(root << FRAC_BITS);
        end
        return acc;
    endfunction

    // adjusted value of one channel sample
    function automatic logic [7:0] adjust_sample(input logic [7:0] p);
        logic [63:0] one;
        logic [63:0] y;
        logic [63:0] lm;
        logic [63:0] lp;
        logic [63:0] mag;
        logic [63:0] d;
        logic [63:0] fd;
        logic [63:0] v;
        logic [63:0] sh;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] q;
        one = 64'd1 << FRAC_BITS;
        if (p == 8'd0)
        begin
            y = (gamma_q == 8'd0) ? one : 64'd0;
        end
        else
        begin
            lm = pix_log2(64'd255);
            lp = pix_log2(64'(p));
            mag = (lp > lm) ? 64'd0 : lm - lp;
            d = (mag * 64'(gamma_q) + 64'd50) / 64'd100;
            fd = d & (one - 64'd1);
            if (fd == 64'd0)
            begin
                v = one;
                sh = d >> FRAC_BITS;
            end
            else
            begin
                v = pow2_frac(one - fd);
                sh = (d >> FRAC_BITS) + 64'd1;
            end
            if (sh >= 64'd63)
            begin
                y = 64'd0;
            end
            else if (sh == 64'd0)
            begin
                y = v;
            end
            else
            begin
                y = (v + (64'd1 << (sh - 64'd1))) >> sh;
            end
        end
        pos = 64'(gain_q) * y * 64'd255 + 64'(offset_q) * 64'd255 * one;
        neg = 64'd100 * 64'd255 * one;
        if (pos <= neg)
        begin
            return 8'd0;
        end
        q = (pos - neg + 64'd50 * one) / (64'd100 * one);
        return (q > 64'd255) ? 8'd255 : q[7:0];
    endfunction

    function automatic logic [23:0] adjust_pixel(input logic [23:0] px);
        return {adjust_sample(px[23:16]), adjust_sample(px[15:8]), adjust_sample(px[7:0])};
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        n_errors++;
        $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, n_results);
    endtask

    // output side: random stall while stalls are enabled, and check of each result transfer
    always @(posedge clk)
    begin
        logic [23:0] want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pixel_queue.size() == 0)
                begin
                    n_errors++;
                    $display("unexpected result %h", m_axis_tdata);
                end
                else
                begin
                    want = pixel_queue.pop_front();
                    if (m_axis_tdata[7:0] != want[7:0])
                        report_mismatch("red_out", m_axis_tdata[7:0], want[7:0]);
                    if (m_axis_tdata[15:8] != want[15:8])
                        report_mismatch("green_out", m_axis_tdata[15:8], want[15:8]);
                    if (m_axis_tdata[23:16] != want[23:16])
                        report_mismatch("blue_out", m_axis_tdata[23:16], want[23:16]);
                end
                n_results++;
            end
            if (!stall_enable)
                m_axis_tready <= 1'b1;
            else if ($urandom_range(0, 99) < 3)
                m_axis_tready <= 1'b0;
            else if (!m_axis_tready && $urandom_range(0, 99) < 15)
                m_axis_tready <= 1'b1;
            else if ($urandom_range(0, 99) < 20)
                m_axis_tready <= ~m_axis_tready;
        end
    end

    // timeout
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // one pixel transfer, with a random gap before it when stalls are enabled
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        int gap;
        gap = 0;
        if (stall_enable)
        begin
            gap = ($urandom_range(0, 9) < 7) ? 0 : (($urandom_range(0, 9) < 8) ?
                  $urandom_range(1, 3) : $urandom_range(8, 30));
        end
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {b, g, r};
        pixel_queue.push_back(adjust_pixel({b, g, r}));
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        n_pixels++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pixel_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // register write, only while idle
    task automatic write_reg(input cfg_reg_t idx, input logic [7:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_CONTRAST:   gain_q = val;
            REG_BRIGHTNESS: offset_q = val;
            default:        gamma_q = val;
        endcase
    endtask

    task automatic set_regs(input logic [7:0] c, input logic [7:0] br, input logic [7:0] gm);
        wait_idle();
        write_reg(REG_CONTRAST, c);
        write_reg(REG_BRIGHTNESS, br);
        write_reg(REG_GAMMA, gm);
    endtask

    // sample extremes and zero samples at the reset settings
    task automatic test_reset_defaults();
        send_pixel(8'd0, 8'd255, 8'd1);
        send_pixel(8'd255, 8'd0, 8'd128);
        send_pixel(8'd170, 8'd85, 8'd254);
    endtask

    // zero gamma, saturation both ways, settings above 200
    task automatic test_special_settings();
        set_regs(8'd100, 8'd100, 8'd0);
        send_pixel(8'd0, 8'd1, 8'd255);
        send_pixel(8'd37, 8'd0, 8'd200);
        set_regs(8'd200, 8'd200, 8'd200);
        send_pixel(8'd0, 8'd255, 8'd64);
        set_regs(8'd0, 8'd0, 8'd1);
        send_pixel(8'd255, 8'd10, 8'd0);
        set_regs(8'd255, 8'd255, 8'd255);
        send_pixel(8'd1, 8'd2, 8'd255);
        set_regs(8'd150, 8'd60, 8'd50);
        send_pixel(8'd15, 8'd240, 8'd100);
        set_regs(8'd201, 8'd99, 8'd220);
        send_pixel(8'd3, 8'd128, 8'd254);
    endtask

    // random pixels across several register settings
    task automatic test_random_pixels();
        for (int phase = 0; phase < 10; phase++)
        begin
            if (phase == 9)
                set_regs(8'd100, 8'd100, 8'd100);
            else
                set_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
                         8'($urandom_range(0, 200)));
            stall_enable = (phase % 4) != 3;
            for (int i = 0; i < 110; i++)
                send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        end
        stall_enable = 1'b1;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b1;
        gain_q = 8'd100;
        offset_q = 8'd100;
        gamma_q = 8'd100;
        n_errors = 0;
        n_pixels = 0;
        n_results = 0;
        cycle_count = 0;
        stall_enable = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_special_settings();
        test_random_pixels();
        wait_idle();

        $display("covered %0d pixels and %0d results over many register settings",
                 n_pixels, n_results);
        if (n_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+hdl
hdl/gcb_pkg.sv
hdl/gcb_chan.sv
hdl/gamma_contrast_brightness_pixel.sv
verif/tb.sv
